### hdl/btp_fragment_reassembler_macros.svh
// Assertion helpers for the fragment reassembler.
`ifndef BTP_FRAGMENT_REASSEMBLER_MACROS_SVH
`define BTP_FRAGMENT_REASSEMBLER_MACROS_SVH
// Implication checked at every clock edge outside reset.
`define BTPR_ASSERT_IMPL(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("btp reassembler check failed");
// Implication whose consequent is checked in the following cycle.
`define BTPR_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("btp reassembler check failed");
`endif

### hdl/btpr_pkg.sv
// ----------------------------------------------------------------------------
// btpr_pkg
// Shared types and constants of the fragment reassembler.
// ----------------------------------------------------------------------------
package btpr_pkg;
   localparam int BufDepth = 1024;
   localparam int AddrW = $clog2(BufDepth);
   localparam int CountW = AddrW + 1;

   typedef enum logic [1:0] {
      MODE_FRAG = 2'd0, MODE_RESET = 2'd1, MODE_READ = 2'd2, MODE_INIT = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      PH_IDLE = 2'd0, PH_BUSY = 2'd1, PH_DONE = 2'd2, PH_ERR = 2'd3
   } phase_type;

   typedef enum logic [2:0] {
      ST_OK = 3'd0, ST_END = 3'd1, ST_STATE = 3'd2, ST_TRUNC = 3'd3, ST_NOSPACE = 3'd4
   } status_type;

   typedef enum logic [2:0] {
      POS_FLAGS = 3'd0, POS_ACK = 3'd1, POS_SEQ = 3'd2, POS_LEN_LO = 3'd3,
      POS_LEN_HI = 3'd4, POS_DATA = 3'd5, POS_SKIP = 3'd6
   } pos_type;

   localparam logic [7:0] FlStart = 8'h01;
   localparam logic [7:0] FlCont = 8'h02;
   localparam logic [7:0] FlEnd = 8'h04;
   localparam logic [7:0] FlAck = 8'h08;
   localparam logic [16:0] PcountMax = 17'h1FFFF;

   localparam logic [1:0] RegCapacity = 2'd0;
   localparam logic [1:0] RegFirstSeq = 2'd1;

   typedef struct packed {
      logic [1:0] mode;
      logic [7:0] frag_byte;
      logic frag_last;
      logic [9:0] read_index;
   } req_type;

   typedef struct packed {
      logic [2:0] status;
      logic ack_present;
      logic [7:0] ack_number;
      logic [7:0] last_sequence;
      logic [10:0] held_length;
      logic [7:0] read_data;
      logic [1:0] phase;
   } rsp_type;

   // Work passed from the parser to the back part.
   typedef struct packed {
      logic wr_en;
      logic [AddrW-1:0] wr_addr;
      logic [7:0] wr_data;
      logic rd_en;
      logic rd_hit;
      logic [AddrW-1:0] rd_addr;
      rsp_type rsp;
   } work_type;
endpackage

### hdl/btpr_parser.sv
// ----------------------------------------------------------------------------
// btpr_parser
// Front part: parses fragment bytes, keeps the protocol state and emits work.
// ----------------------------------------------------------------------------
module btpr_parser (
   input logic clock,
   input logic reset,
   input logic in_valid,
   input btpr_pkg::req_type req,
   input logic [10:0] capacity,
   input logic [7:0] seq_start,
   output logic out_valid,
   output btpr_pkg::work_type work
);
   btpr_pkg::phase_type phase_ff, phase_in;
   btpr_pkg::pos_type pos_ff, pos_in;
   btpr_pkg::status_type perr_ff, perr_in;
   logic [7:0] exp_ff, exp_in, acc_ff, acc_in, ack_ff, ack_in, flags_ff, flags_in;
   logic ackf_ff, ackf_in;
   logic [15:0] decl_ff, decl_in;
   logic [10:0] held_ff, held_in;
   logic [16:0] pcnt_ff, pcnt_in;
   logic [10:0] cap;
   logic [17:0] total;
   logic [15:0] len_full;

   // Raise an error once; later faults keep the first status.
   function automatic btpr_pkg::status_type keep_err(btpr_pkg::status_type cur,
                                                      btpr_pkg::status_type code);
      return (cur == btpr_pkg::ST_OK) ? code : cur;
   endfunction

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= btpr_pkg::PH_IDLE;
         pos_ff <= btpr_pkg::POS_FLAGS;
         perr_ff <= btpr_pkg::ST_OK;
         exp_ff <= 8'd0;
         acc_ff <= 8'd0;
         ack_ff <= 8'd0;
         flags_ff <= 8'd0;
         ackf_ff <= 1'b0;
         decl_ff <= 16'd0;
         held_ff <= 11'd0;
         pcnt_ff <= 17'd0;
      end else if (in_valid) begin
         phase_ff <= phase_in;
         pos_ff <= pos_in;
         perr_ff <= perr_in;
         exp_ff <= exp_in;
         acc_ff <= acc_in;
         ack_ff <= ack_in;
         flags_ff <= flags_in;
         ackf_ff <= ackf_in;
         decl_ff <= decl_in;
         held_ff <= held_in;
         pcnt_ff <= pcnt_in;
      end
   end

   always_comb begin
      cap = (capacity > 11'(btpr_pkg::BufDepth)) ? 11'(btpr_pkg::BufDepth) : capacity;
      phase_in = phase_ff;
      pos_in = pos_ff;
      perr_in = perr_ff;
      exp_in = exp_ff;
      acc_in = acc_ff;
      ack_in = ack_ff;
      flags_in = flags_ff;
      ackf_in = ackf_ff;
      decl_in = decl_ff;
      held_in = held_ff;
      pcnt_in = pcnt_ff;
      total = 18'(held_ff) + 18'(pcnt_ff);
      len_full = {req.frag_byte, decl_ff[7:0]};
      work = '0;
      out_valid = 1'b0;
      work.rsp.status = btpr_pkg::ST_OK;
      unique case (btpr_pkg::mode_type'(req.mode))
         btpr_pkg::MODE_FRAG: begin
            unique case (pos_ff)
               btpr_pkg::POS_FLAGS: begin
                  pcnt_in = 17'd0;
                  perr_in = btpr_pkg::ST_OK;
                  if (phase_ff == btpr_pkg::PH_ERR) begin
                     perr_in = btpr_pkg::ST_STATE;
                     pos_in = btpr_pkg::POS_SKIP;
                  end else begin
                     flags_in = req.frag_byte;
                     ackf_in = 1'b0;
                     pos_in = ((req.frag_byte & btpr_pkg::FlAck) != 8'd0) ?
                              btpr_pkg::POS_ACK : btpr_pkg::POS_SEQ;
                  end
               end
               btpr_pkg::POS_ACK: begin
                  ack_in = req.frag_byte;
                  ackf_in = 1'b1;
                  pos_in = btpr_pkg::POS_SEQ;
               end
               btpr_pkg::POS_SEQ: begin
                  if (req.frag_byte != exp_ff) begin
                     perr_in = keep_err(perr_ff, btpr_pkg::ST_STATE);
                     phase_in = btpr_pkg::PH_ERR;
                     pos_in = btpr_pkg::POS_SKIP;
                  end else begin
                     acc_in = req.frag_byte;
                     exp_in = exp_ff + 8'd1;
                     if ((flags_ff & (btpr_pkg::FlStart | btpr_pkg::FlCont |
                                      btpr_pkg::FlEnd)) == 8'd0) begin
                        pos_in = btpr_pkg::POS_SKIP;
                     end else if (phase_ff == btpr_pkg::PH_IDLE &&
                                  (flags_ff & btpr_pkg::FlStart) != 8'd0) begin
                        pos_in = btpr_pkg::POS_LEN_LO;
                     end else if (phase_ff == btpr_pkg::PH_BUSY &&
                                  (flags_ff & btpr_pkg::FlStart) == 8'd0) begin
                        pos_in = btpr_pkg::POS_DATA;
                     end else begin
                        perr_in = keep_err(perr_ff, btpr_pkg::ST_STATE);
                        phase_in = btpr_pkg::PH_ERR;
                        pos_in = btpr_pkg::POS_SKIP;
                     end
                  end
               end
               btpr_pkg::POS_LEN_LO: begin
                  decl_in = {8'd0, req.frag_byte};
                  pos_in = btpr_pkg::POS_LEN_HI;
               end
               btpr_pkg::POS_LEN_HI: begin
                  decl_in = len_full;
                  if (len_full > 16'(cap)) begin
                     perr_in = keep_err(perr_ff, btpr_pkg::ST_NOSPACE);
                     phase_in = btpr_pkg::PH_ERR;
                     pos_in = btpr_pkg::POS_SKIP;
                  end else begin
                     held_in = 11'd0;
                     phase_in = btpr_pkg::PH_BUSY;
                     pos_in = btpr_pkg::POS_DATA;
                  end
               end
               btpr_pkg::POS_DATA: begin
                  if (total < 18'(cap) && total < 18'(decl_ff)) begin
                     work.wr_en = 1'b1;
                     work.wr_addr = total[btpr_pkg::AddrW-1:0];
                     work.wr_data = req.frag_byte;
                  end
                  if (pcnt_ff != btpr_pkg::PcountMax) pcnt_in = pcnt_ff + 17'd1;
               end
               default: ;
            endcase
            if (req.frag_last) begin
               // The fragment ends; check it using the counts updated above.
               total = 18'(held_in) + 18'(pcnt_in);
               if (perr_in == btpr_pkg::ST_OK) begin
                  if (pos_in == btpr_pkg::POS_ACK || pos_in == btpr_pkg::POS_SEQ ||
                      pos_in == btpr_pkg::POS_LEN_LO || pos_in == btpr_pkg::POS_LEN_HI) begin
                     perr_in = btpr_pkg::ST_TRUNC;
                     phase_in = btpr_pkg::PH_ERR;
                  end else if (pos_in == btpr_pkg::POS_DATA) begin
                     if (total > 18'(cap)) begin
                        perr_in = btpr_pkg::ST_NOSPACE;
                        phase_in = btpr_pkg::PH_ERR;
                     end else if (total > 18'(decl_in)) begin
                        perr_in = btpr_pkg::ST_STATE;
                        phase_in = btpr_pkg::PH_ERR;
                     end else begin
                        held_in = total[10:0];
                        if ((flags_in & btpr_pkg::FlEnd) != 8'd0) begin
                           if (18'(decl_in) != total) begin
                              perr_in = btpr_pkg::ST_TRUNC;
                              phase_in = btpr_pkg::PH_ERR;
                           end else begin
                              phase_in = btpr_pkg::PH_DONE;
                              perr_in = btpr_pkg::ST_END;
                           end
                        end
                     end
                  end
               end
               work.rsp.status = perr_in;
               out_valid = 1'b1;
               pos_in = btpr_pkg::POS_FLAGS;
               perr_in = btpr_pkg::ST_OK;
               pcnt_in = 17'd0;
            end
         end
         btpr_pkg::MODE_RESET: begin
            out_valid = 1'b1;
            if (phase_ff == btpr_pkg::PH_ERR) begin
               work.rsp.status = btpr_pkg::ST_STATE;
            end else begin
               held_in = 11'd0;
               decl_in = 16'd0;
               phase_in = btpr_pkg::PH_IDLE;
               ackf_in = 1'b0;
               pos_in = btpr_pkg::POS_FLAGS;
               perr_in = btpr_pkg::ST_OK;
               pcnt_in = 17'd0;
               flags_in = 8'd0;
            end
         end
         btpr_pkg::MODE_READ: begin
            out_valid = 1'b1;
            work.rd_en = 1'b1;
            work.rd_hit = 11'(req.read_index) < held_ff;
            work.rd_addr = req.read_index[btpr_pkg::AddrW-1:0];
         end
         default: begin
            out_valid = 1'b1;
            phase_in = btpr_pkg::PH_IDLE;
            exp_in = seq_start;
            acc_in = 8'd0;
            ack_in = 8'd0;
            ackf_in = 1'b0;
            decl_in = 16'd0;
            held_in = 11'd0;
            pos_in = btpr_pkg::POS_FLAGS;
            perr_in = btpr_pkg::ST_OK;
            pcnt_in = 17'd0;
            flags_in = 8'd0;
         end
      endcase
      work.rsp.ack_present = ackf_in;
      work.rsp.ack_number = ack_in;
      work.rsp.last_sequence = acc_in;
      work.rsp.held_length = held_in;
      work.rsp.read_data = 8'd0;
      work.rsp.phase = phase_in;
      out_valid = out_valid & in_valid;
      work.wr_en = work.wr_en & in_valid;
   end
endmodule

### hdl/btpr_back.sv
// ----------------------------------------------------------------------------
// btpr_back
// Back part: message store, read port and three-entry result queue.
// ----------------------------------------------------------------------------
module btpr_back (
   input logic clock,
   input logic reset,
   input logic in_valid,
   input btpr_pkg::work_type work,
   output logic full,
   output logic empty,
   input logic pop,
   output btpr_pkg::rsp_type rsp
);
   logic [7:0] mem [btpr_pkg::BufDepth];
   logic [7:0] rd_ff;
   logic stg_valid_ff, stg_valid_in;
   logic stg_hit_ff;
   btpr_pkg::rsp_type stg_ff;
   btpr_pkg::rsp_type q_ff [3];
   logic [1:0] cnt_ff, cnt_in;
   logic [1:0] wptr_ff, rptr_ff;
   logic push_q, pop_q;
   btpr_pkg::rsp_type stg_out;

   // Queue pointers step through the three slots and wrap.
   function automatic logic [1:0] step_ptr(logic [1:0] p);
      return (p == 2'd2) ? 2'd0 : p + 2'd1;
   endfunction

   // Writes happen before any read that follows them, as in item order.
   always_ff @(posedge clock) begin
      if (work.wr_en) mem[work.wr_addr] <= work.wr_data;
      if (in_valid && work.rd_en) rd_ff <= mem[work.rd_addr];
   end

   always_comb begin
      stg_out = stg_ff;
      stg_out.read_data = stg_hit_ff ? rd_ff : 8'd0;
      push_q = stg_valid_ff;
      pop_q = pop && !empty;
      cnt_in = cnt_ff + {1'b0, push_q} - {1'b0, pop_q};
      stg_valid_in = in_valid;
      // One staging slot plus three queue slots; stop taking items once the
      // staged and queued results could fill the queue, without looking at pop.
      full = (cnt_ff == 2'd3) || (cnt_ff == 2'd2 && stg_valid_ff);
      empty = (cnt_ff == 2'd0);
      rsp = q_ff[rptr_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stg_valid_ff <= 1'b0;
         cnt_ff <= 2'd0;
         wptr_ff <= 2'd0;
         rptr_ff <= 2'd0;
      end else begin
         stg_valid_ff <= stg_valid_in;
         cnt_ff <= cnt_in;
         if (push_q) wptr_ff <= step_ptr(wptr_ff);
         if (pop_q) rptr_ff <= step_ptr(rptr_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid) begin
         stg_ff <= work.rsp;
         stg_hit_ff <= work.rd_en & work.rd_hit;
      end
      if (push_q) q_ff[wptr_ff] <= stg_out;
   end
endmodule

### hdl/btpr_csr.sv
// ----------------------------------------------------------------------------
// btpr_csr
// Configuration registers behind the APB-style port.
// ----------------------------------------------------------------------------
module btpr_csr (
   input logic clock,
   input logic reset,
   input logic psel,
   input logic penable,
   input logic pwrite,
   input logic [2:0] paddr,
   input logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic pready,
   output logic [10:0] capacity,
   output logic [7:0] seq_start
);
   logic [10:0] cap_ff;
   logic [7:0] fseq_ff;
   logic wr;

   assign pready = 1'b1;
   assign wr = psel && penable && pwrite;
   assign capacity = cap_ff;
   assign seq_start = fseq_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff <= 11'd1024;
         fseq_ff <= 8'd0;
      end else if (wr) begin
         if (paddr[2:2] == 1'(btpr_pkg::RegCapacity)) cap_ff <= pwdata[10:0];
         else fseq_ff <= pwdata[7:0];
      end
   end

   always_comb begin
      unique case (paddr[2:2])
         1'(btpr_pkg::RegCapacity): prdata = {21'd0, cap_ff};
         default: prdata = {24'd0, fseq_ff};
      endcase
   end
endmodule

### hdl/btp_fragment_reassembler.sv
// ----------------------------------------------------------------------------
// btp_fragment_reassembler
// Byte-serial BTP receive reassembly with a message store and result queue.
// ----------------------------------------------------------------------------
// The block takes one item per clock while req_full is low. Each fragment
// byte is parsed in the cycle it arrives; a payload byte is written to the
// 1024-byte store in that cycle. A result passes through the staging
// register, where a store read completes, before it enters the three-entry
// result queue. With pop held high the rate is one item per cycle. full
// rises only when the queued results and the staged one could fill the
// queue, and it does not depend on pop in the same cycle.
// Configuration writes take effect at the APB access edge and must be made
// while no results are outstanding.
module btp_fragment_reassembler (
   input logic clock,
   input logic reset,
   input logic req_push,
   output logic req_full,
   input btpr_pkg::req_type req_data,
   output logic rsp_empty,
   input logic rsp_pop,
   output btpr_pkg::rsp_type rsp_data,
   input logic csr_psel,
   input logic csr_penable,
   input logic csr_pwrite,
   input logic [2:0] csr_paddr,
   input logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic csr_pready
);
   logic [10:0] capacity;
   logic [7:0] seq_start;
   logic accept;
   logic work_valid;
   btpr_pkg::work_type work;

   // The parser state only moves on accepted items.
   assign accept = req_push && !req_full;

   btpr_csr u_csr (
      .clock(clock), .reset(reset),
      .psel(csr_psel), .penable(csr_penable), .pwrite(csr_pwrite),
      .paddr(csr_paddr), .pwdata(csr_pwdata), .prdata(csr_prdata),
      .pready(csr_pready), .capacity(capacity), .seq_start(seq_start)
   );

   btpr_parser u_parser (
      .clock(clock), .reset(reset), .in_valid(accept), .req(req_data),
      .capacity(capacity), .seq_start(seq_start),
      .out_valid(work_valid), .work(work)
   );

   btpr_back u_back (
      .clock(clock), .reset(reset), .in_valid(work_valid), .work(work),
      .full(req_full), .empty(rsp_empty), .pop(rsp_pop), .rsp(rsp_data)
   );
endmodule

### hdl/btpr_checker.sv
// ----------------------------------------------------------------------------
// btpr_checker
// Port-level checks of the reassembler.
// ----------------------------------------------------------------------------
`include "btp_fragment_reassembler_macros.svh"
module btpr_checker (
   input logic clock,
   input logic reset,
   input logic req_full,
   input logic rsp_empty,
   input logic rsp_pop,
   input btpr_pkg::rsp_type rsp_data,
   input logic csr_pready
);
   `BTPR_ASSERT_IMPL(a_pready, 1'b1, csr_pready)
   `BTPR_ASSERT_NEXT(a_hold, !rsp_empty && !rsp_pop, !rsp_empty && $stable(rsp_data))
   `BTPR_ASSERT_IMPL(a_status, !rsp_empty, rsp_data.status <= btpr_pkg::ST_NOSPACE)
   `BTPR_ASSERT_IMPL(a_done, !rsp_empty && rsp_data.status == btpr_pkg::ST_END, rsp_data.phase == btpr_pkg::PH_DONE)
   `BTPR_ASSERT_IMPL(a_full_busy, req_full, !rsp_empty)
endmodule

bind btp_fragment_reassembler btpr_checker u_checker (
   .clock(clock), .reset(reset), .req_full(req_full),
   .rsp_empty(rsp_empty), .rsp_pop(rsp_pop), .rsp_data(rsp_data),
   .csr_pready(csr_pready)
);

### tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the BTP fragment reassembler. A predictor of the
// fragment parser and message store forms each expected result;
// results popped from the block are compared field by field in order.
// ----------------------------------------------------------------------------
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CycleLimit = 1500000;
   localparam logic [16:0] PayloadMax = 17'h1FFFF;

   logic clock;
   logic reset;
   logic req_push = 1'b0;
   logic req_full;
   btpr_pkg::req_type req_data = '0;
   logic rsp_empty;
   logic rsp_pop = 1'b0;
   btpr_pkg::rsp_type rsp_data;
   logic csr_psel;
   logic csr_penable;
   logic csr_pwrite;
   logic [2:0] csr_paddr;
   logic [31:0] csr_pwdata;
   logic [31:0] csr_prdata;
   logic csr_pready;

   btp_fragment_reassembler dut (.*);

   // Items waiting for the driver and results waiting for the monitor.
   btpr_pkg::req_type pending_items[$];
   btpr_pkg::rsp_type expected_results[$];

   int mismatches = 0;
   int cycle_count = 0;
   int send_gap = 0;
   int pop_gap = 0;
   bit hold_request = 1'b0;
   bit hold_off = 1'b0;
   bit sender_pause = 1'b0;

   // Predictor state. It mirrors the reassembler's registers.
   logic [10:0] cap_reg;
   logic [7:0] seq_start_reg;
   btpr_pkg::phase_type msg_phase;
   logic [7:0] seq_expected;
   logic [7:0] seq_accepted;
   logic [7:0] ack_num;
   logic ack_seen;
   logic [15:0] msg_length;
   logic [10:0] held;
   logic [7:0] store_copy[btpr_pkg::BufDepth];
   btpr_pkg::pos_type parse_pos;
   logic [7:0] flags_byte;
   btpr_pkg::status_type frag_status;
   logic [16:0] frag_payload;

   initial begin
      clock = 0;
      forever #4 clock = ~clock;
   end

   function automatic int unsigned usable_space();
      return (cap_reg < btpr_pkg::BufDepth) ? cap_reg : btpr_pkg::BufDepth;
   endfunction

   // Records the first fault of a fragment and skips its remaining bytes.
   function automatic void flag_fault(btpr_pkg::status_type code);
      if (frag_status == btpr_pkg::ST_OK) frag_status = code;
      msg_phase = btpr_pkg::PH_ERR;
      parse_pos = btpr_pkg::POS_SKIP;
   endfunction

   function automatic void drop_fragment();
      parse_pos = btpr_pkg::POS_FLAGS;
      frag_status = btpr_pkg::ST_OK;
      frag_payload = '0;
      flags_byte = '0;
   endfunction

   function automatic void restart_connection();
      msg_phase = btpr_pkg::PH_IDLE;
      seq_expected = seq_start_reg;
      seq_accepted = '0;
      ack_num = '0;
      ack_seen = 1'b0;
      msg_length = '0;
      held = '0;
      drop_fragment();
   endfunction

   function automatic void parse_byte(logic [7:0] b);
      int unsigned offset;
      case (parse_pos)
         btpr_pkg::POS_FLAGS: begin
            frag_payload = '0;
            frag_status = btpr_pkg::ST_OK;
            if (msg_phase == btpr_pkg::PH_ERR) begin
               frag_status = btpr_pkg::ST_STATE;
               parse_pos = btpr_pkg::POS_SKIP;
            end else begin
               flags_byte = b;
               ack_seen = 1'b0;
               parse_pos = ((b & btpr_pkg::FlAck) != 8'd0) ? btpr_pkg::POS_ACK
                                                           : btpr_pkg::POS_SEQ;
            end
         end
         btpr_pkg::POS_ACK: begin
            ack_num = b;
            ack_seen = 1'b1;
            parse_pos = btpr_pkg::POS_SEQ;
         end
         btpr_pkg::POS_SEQ: begin
            if (b != seq_expected) flag_fault(btpr_pkg::ST_STATE);
            else begin
               seq_accepted = b;
               seq_expected = seq_expected + 8'd1;
               if ((flags_byte & (btpr_pkg::FlStart | btpr_pkg::FlCont |
                                  btpr_pkg::FlEnd)) == 8'd0)
                  parse_pos = btpr_pkg::POS_SKIP;
               else if (msg_phase == btpr_pkg::PH_IDLE) begin
                  if ((flags_byte & btpr_pkg::FlStart) == 8'd0)
                     flag_fault(btpr_pkg::ST_STATE);
                  else parse_pos = btpr_pkg::POS_LEN_LO;
               end else if (msg_phase == btpr_pkg::PH_BUSY) begin
                  if ((flags_byte & btpr_pkg::FlStart) != 8'd0)
                     flag_fault(btpr_pkg::ST_STATE);
                  else parse_pos = btpr_pkg::POS_DATA;
               end else flag_fault(btpr_pkg::ST_STATE);
            end
         end
         btpr_pkg::POS_LEN_LO: begin
            msg_length = {8'd0, b};
            parse_pos = btpr_pkg::POS_LEN_HI;
         end
         btpr_pkg::POS_LEN_HI: begin
            msg_length[15:8] = b;
            if (msg_length > usable_space()) flag_fault(btpr_pkg::ST_NOSPACE);
            else begin
               held = '0;
               msg_phase = btpr_pkg::PH_BUSY;
               parse_pos = btpr_pkg::POS_DATA;
            end
         end
         btpr_pkg::POS_DATA: begin
            offset = held + frag_payload;
            if (offset < usable_space() && offset < msg_length &&
                offset < btpr_pkg::BufDepth)
               store_copy[offset] = b;
            if (frag_payload < PayloadMax) frag_payload = frag_payload + 17'd1;
         end
         default: ;
      endcase
   endfunction

   function automatic btpr_pkg::status_type close_fragment();
      int unsigned total;
      btpr_pkg::status_type st;
      if (frag_status == btpr_pkg::ST_OK) begin
         if (parse_pos inside {btpr_pkg::POS_ACK, btpr_pkg::POS_SEQ,
                               btpr_pkg::POS_LEN_LO, btpr_pkg::POS_LEN_HI})
            flag_fault(btpr_pkg::ST_TRUNC);
         else if (parse_pos == btpr_pkg::POS_DATA) begin
            total = held + frag_payload;
            if (total > usable_space()) flag_fault(btpr_pkg::ST_NOSPACE);
            else if (total > msg_length) flag_fault(btpr_pkg::ST_STATE);
            else begin
               held = 11'(total);
               if ((flags_byte & btpr_pkg::FlEnd) != 8'd0) begin
                  if (held != msg_length) flag_fault(btpr_pkg::ST_TRUNC);
                  else begin
                     msg_phase = btpr_pkg::PH_DONE;
                     frag_status = btpr_pkg::ST_END;
                  end
               end
            end
         end
      end
      st = frag_status;
      parse_pos = btpr_pkg::POS_FLAGS;
      frag_status = btpr_pkg::ST_OK;
      frag_payload = '0;
      return st;
   endfunction

   // Runs one item through the predictor and queues its result, if any.
   function automatic void predict_item(btpr_pkg::req_type it);
      btpr_pkg::rsp_type r;
      r = '0;
      r.status = btpr_pkg::ST_OK;
      case (btpr_pkg::mode_type'(it.mode))
         btpr_pkg::MODE_FRAG: begin
            parse_byte(it.frag_byte);
            if (!it.frag_last) return;
            r.status = close_fragment();
         end
         btpr_pkg::MODE_RESET: begin
            if (msg_phase == btpr_pkg::PH_ERR) r.status = btpr_pkg::ST_STATE;
            else begin
               held = '0;
               msg_length = '0;
               msg_phase = btpr_pkg::PH_IDLE;
               ack_seen = 1'b0;
               drop_fragment();
            end
         end
         btpr_pkg::MODE_READ:
            if (it.read_index < held) r.read_data = store_copy[it.read_index];
         default: restart_connection();
      endcase
      r.ack_present = ack_seen;
      r.ack_number = ack_num;
      r.last_sequence = seq_accepted;
      r.held_length = held;
      r.phase = msg_phase;
      expected_results.push_back(r);
   endfunction

   // Driver: takes the next pending item, holding it until the block accepts it.
   always @(posedge clock) begin
      if (reset) begin
         req_push <= 1'b0;
      end else begin
         if (req_push && !req_full) void'(pending_items.pop_front());
         if (send_gap > 0) send_gap--;
         if (!req_push || !req_full) begin
            if (!sender_pause && send_gap == 0 && pending_items.size() > 0 &&
                $urandom_range(0, 99) < 80) begin
               req_push <= 1'b1;
               req_data <= pending_items[0];
               predict_item(pending_items[0]);
               // Now and then a long pause follows the item.
               if ($urandom_range(0, 99) == 0) send_gap = $urandom_range(20, 60);
            end else req_push <= 1'b0;
         end
      end
   end

   // Monitor: pops results with random stalls and compares them in order.
   always @(posedge clock) begin
      btpr_pkg::rsp_type exp_r;
      if (reset) begin
         rsp_pop <= 1'b0;
      end else begin
         if (rsp_pop && !rsp_empty) begin
            if (expected_results.size() == 0) begin
               mismatches++;
               if (mismatches <= 10) $display("unexpected result %p", rsp_data);
            end else begin
               exp_r = expected_results.pop_front();
               if (rsp_data !== exp_r) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("mismatch: expected %p, actual %p", exp_r, rsp_data);
               end
            end
         end
         if (pop_gap > 0) pop_gap--;
         if (hold_off || pop_gap > 0) rsp_pop <= 1'b0;
         else begin
            rsp_pop <= ($urandom_range(0, 99) < 75);
            if ($urandom_range(0, 199) == 0) pop_gap = $urandom_range(20, 60);
         end
      end
   end

   // Receiver hold-off: once requested, the monitor stops taking results, then resumes.
   initial begin
      wait (hold_request);
      hold_off = 1'b1;
      repeat (300) @(posedge clock);
      hold_off = 1'b0;
   end

   // The predictor is advanced when the driver offers an item, so an item that
   // is offered but not yet accepted must not be predicted twice. The driver
   // only offers a new item after the previous one was accepted.

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CycleLimit) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   task automatic wait_drained();
      while (pending_items.size() > 0 || req_push || expected_results.size() > 0)
         @(posedge clock);
      repeat (6) @(posedge clock);
   endtask

   task automatic csr_write(logic [1:0] idx, logic [31:0] value);
      csr_paddr <= {idx[0], 2'b00};
      csr_pwdata <= value;
      csr_pwrite <= 1'b1;
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      if (idx == btpr_pkg::RegCapacity) cap_reg = value[10:0];
      else seq_start_reg = value[7:0];
   endtask

   function automatic btpr_pkg::req_type make_item(btpr_pkg::mode_type m, logic [7:0] b,
                                                   logic l, logic [9:0] ix);
      btpr_pkg::req_type it;
      it.mode = m;
      it.frag_byte = b;
      it.frag_last = l;
      it.read_index = ix;
      return it;
   endfunction

   function automatic void add_frag(logic [7:0] b, logic l);
      pending_items.push_back(make_item(btpr_pkg::MODE_FRAG, b, l, 10'($urandom)));
   endfunction

   // Queues one fragment; sequence usually matches the predicted next value.
   function automatic void queue_fragment(logic [7:0] flags, logic [7:0] seq,
                                          int unsigned len, int unsigned npay);
      int unsigned total_bytes;
      int unsigned k;
      logic [7:0] hdr[$];
      hdr.push_back(flags);
      if ((flags & btpr_pkg::FlAck) != 8'd0) hdr.push_back(8'($urandom));
      hdr.push_back(seq);
      if ((flags & btpr_pkg::FlStart) != 8'd0) begin
         hdr.push_back(len[7:0]);
         hdr.push_back(len[15:8]);
      end
      total_bytes = hdr.size() + npay;
      for (k = 0; k < total_bytes; k++)
         add_frag(k < hdr.size() ? hdr[k] : 8'($urandom), k == total_bytes - 1);
   endfunction

   initial begin
      logic [7:0] seq;
      int unsigned len, remain, chunk, n, kind, maxc;
      bit big, long_left;
      logic [7:0] fl;
      reset = 1;
      csr_psel = 0;
      csr_penable = 0;
      csr_pwrite = 0;
      csr_paddr = '0;
      csr_pwdata = '0;
      cap_reg = 11'd1024;
      seq_start_reg = 8'd0;
      for (int i = 0; i < btpr_pkg::BufDepth; i++) store_copy[i] = 8'd0;
      restart_connection();
      repeat (9) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // Directed part: a full message, reads, a standalone ack, faults.
      queue_fragment(btpr_pkg::FlStart | btpr_pkg::FlAck, 8'd0, 4, 2);
      queue_fragment(btpr_pkg::FlCont, 8'd1, 0, 1);
      queue_fragment(btpr_pkg::FlEnd, 8'd2, 0, 1);
      pending_items.push_back(make_item(btpr_pkg::MODE_READ, 8'd0, 1'b0, 10'd3));
      pending_items.push_back(make_item(btpr_pkg::MODE_READ, 8'hFF, 1'b1, 10'd1023));
      queue_fragment(btpr_pkg::FlAck, 8'd3, 0, 2);   // standalone ack with trailing bytes
      queue_fragment(btpr_pkg::FlCont, 8'd4, 0, 0);  // data in complete phase
      queue_fragment(btpr_pkg::FlStart, 8'd0, 0, 0); // fragment while in error
      pending_items.push_back(make_item(btpr_pkg::MODE_RESET, 8'd0, 1'b0, 10'd0));
      pending_items.push_back(make_item(btpr_pkg::MODE_INIT, 8'd0, 1'b0, 10'd0));
      add_frag(btpr_pkg::FlStart | btpr_pkg::FlAck, 1'b0);
      add_frag(8'hAA, 1'b1);                         // short fragment
      pending_items.push_back(make_item(btpr_pkg::MODE_INIT, 8'd0, 1'b0, 10'd0));
      queue_fragment(btpr_pkg::FlStart, 8'd0, 16'hFFFF, 0); // declared length too big
      wait_drained();

      // Capacity extremes and a different first sequence.
      csr_write(btpr_pkg::RegCapacity, 32'd0);
      csr_write(btpr_pkg::RegFirstSeq, 32'd255);
      pending_items.push_back(make_item(btpr_pkg::MODE_INIT, 8'd0, 1'b0, 10'd0));
      queue_fragment(btpr_pkg::FlStart | btpr_pkg::FlEnd, 8'd255, 0, 0);
      queue_fragment(btpr_pkg::FlStart, 8'd0, 1, 0);
      pending_items.push_back(make_item(btpr_pkg::MODE_INIT, 8'd0, 1'b0, 10'd0));
      wait_drained();
      csr_write(btpr_pkg::RegCapacity, 32'd2047);

      // Random part, in phases with different settings. The third phase
      // starts with one message near the full store size.
      for (int ph = 0; ph < 4; ph++) begin
         if (ph == 1) csr_write(btpr_pkg::RegCapacity, 32'd40);
         if (ph == 2) csr_write(btpr_pkg::RegCapacity, 32'd1024);
         if (ph == 3) csr_write(btpr_pkg::RegCapacity, 32'd1023);
         csr_write(btpr_pkg::RegFirstSeq, $urandom_range(0, 255));
         pending_items.push_back(make_item(btpr_pkg::MODE_INIT, 8'd0, 1'b0, 10'd0));
         seq = seq_start_reg;
         long_left = (ph == 2);
         while (pending_items.size() < 130) begin
            kind = $urandom_range(0, 99);
            if (long_left || kind < 70) begin
               // Well-formed message, occasionally with a fault inserted.
               big = long_left;
               long_left = 0;
               if (big) len = $urandom_range(1000, 1030);
               else len = ($urandom_range(0, 19) == 0) ? $urandom_range(25, 60)
                                                      : $urandom_range(0, 24);
               maxc = big ? 120 : 12;
               remain = len;
               n = 0;
               do begin
                  chunk = (remain > maxc) ? $urandom_range(0, maxc) : remain;
                  if ($urandom_range(0, 15) == 0) chunk = chunk + 1;
                  fl = (n == 0) ? btpr_pkg::FlStart : btpr_pkg::FlCont;
                  if (remain <= chunk) fl = fl | btpr_pkg::FlEnd;
                  if ($urandom_range(0, 3) == 0) fl = fl | btpr_pkg::FlAck;
                  queue_fragment(fl, ($urandom_range(0, 30) == 0) ? 8'($urandom) : seq,
                                 len, chunk);
                  seq = seq + 8'd1;
                  remain = (remain > chunk) ? remain - chunk : 0;
                  n++;
               end while ((fl & btpr_pkg::FlEnd) == 8'd0);
               if ($urandom_range(0, 1)) begin
                  pending_items.push_back(make_item(btpr_pkg::MODE_READ, 8'd0, 1'b0,
                     10'($urandom_range(0, len + 2))));
                  pending_items.push_back(make_item(btpr_pkg::MODE_READ, 8'd0, 1'b0,
                     10'($urandom)));
               end
            end else if (kind < 78) begin
               queue_fragment(8'($urandom_range(0, 255)) & ~btpr_pkg::FlStart |
                              btpr_pkg::FlAck, seq, 0, $urandom_range(0, 3));
               seq = seq + 8'd1;
            end else if (kind < 86) begin
               n = $urandom_range(1, 6);
               for (int k = 0; k < n; k++) add_frag(8'($urandom), k == n - 1);
            end else if (kind < 92) begin
               add_frag(8'($urandom), 1'b0);
               pending_items.push_back(make_item(btpr_pkg::MODE_RESET, 8'($urandom),
                                                 1'($urandom), 10'($urandom)));
            end else begin
               pending_items.push_back(make_item(btpr_pkg::MODE_INIT, 8'($urandom),
                                                 1'($urandom), 10'($urandom)));
               seq = seq_start_reg;
            end
         end
         if (ph == 1) hold_request = 1'b1; // receiver stall while the sender pushes
         if (ph == 2) begin
            // Sender pauses mid-stream until every expected result has come.
            while (pending_items.size() > 500) @(posedge clock);
            sender_pause = 1'b1;
            while (expected_results.size() > 0 || req_push) @(posedge clock);
            sender_pause = 1'b0;
         end
         while (pending_items.size() > 0) @(posedge clock);
         wait_drained();
      end

      wait_drained();
      if (mismatches == 0 && expected_results.size() == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end
endmodule

### files.f
+incdir+hdl
hdl/btpr_pkg.sv
hdl/btpr_parser.sv
hdl/btpr_back.sv
hdl/btpr_csr.sv
hdl/btp_fragment_reassembler.sv
hdl/btpr_checker.sv
tb/tb_top.sv
